// ----- hw/rtl/otp_pkg.sv -----
// Shared types, codes and CRC helpers for the one-wire touch panel master.
// Used by every module of the block; depends on nothing else.

package otp_pkg;

	// Depth of the input queue and of the result queue.
	localparam int QUEUE_DEPTH = 4;

	// Configuration port widths and register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PREAMBLE_UNITS  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_LOW_UNITS = 2'd2;

	localparam logic [2:0] RETRY_LIMIT_RESET     = 3'd3;
	localparam logic [7:0] PREAMBLE_UNITS_RESET  = 8'd60;
	localparam logic [3:0] START_LOW_UNITS_RESET = 4'd2;

	// Operation codes of an input beat.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_TOUCH = 2'd1;
	localparam logic [1:0] OP_LIGHT = 2'd2;

	// Work kinds handed from the front to the engine.
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_TOUCH  = 2'd1;
	localparam logic [1:0] KIND_LIGHT  = 2'd2;
	localparam logic [1:0] KIND_IGNORE = 2'd3;

	// Pen event codes.
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_PRESS   = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;

	// Protocol constants.
	localparam logic [7:0]  CRC_INIT   = 8'hAC;
	localparam logic [7:0]  CRC_POLY   = 8'h07;
	localparam logic [7:0]  REQ_LIGHT  = 8'h80;
	localparam logic [7:0]  REQ_TOUCH  = 8'h40;
	localparam logic [7:0]  BRIGHT_MAX = 8'd127;
	localparam logic [11:0] POS_NONE   = 12'hFFF;
	localparam logic [5:0]  TX_BITS     = 6'd16;
	localparam logic [5:0]  RX_CRC_BITS = 6'd24;
	localparam logic [5:0]  RX_BITS     = 6'd32;

	typedef struct packed {
		logic [1:0] operation;
		logic       line_sample;
		logic [7:0] brightness;
	} in_item_t;

	typedef struct packed {
		logic        drive_enable;
		logic        drive_level;
		logic        busy_res;
		logic        done_res;
		logic        success;
		logic        pen_down;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [1:0]  pen_event;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        sample;
		logic [15:0] frame;
	} work_t;

	typedef struct packed {
		logic [2:0] retry_limit;
		logic [7:0] preamble_units;
		logic [3:0] start_low_units;
	} cfg_t;

	// One CRC8 step: shift, fold the dropped top bit, then fold the data bit.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic data_bit);
		logic [7:0] c;
		c = {crc[6:0], 1'b0};
		if (crc[7]) c = c ^ CRC_POLY;
		if (data_bit) c = c ^ CRC_POLY;
		return c;
	endfunction

	// CRC8 of one byte, MSB first, from the initial value.
	function automatic logic [7:0] crc8_byte(input logic [7:0] data);
		logic [7:0] c;
		c = CRC_INIT;
		for (int i = 7; i >= 0; i--) begin
			c = crc8_step(c, data[i]);
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/otp_front.sv -----
// Front of the touch panel master: accepts input beats, classifies them
// and builds the request frame, then queues the work. Depends on otp_pkg.

module otp_front #(
	parameter int Depth = otp_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  otp_pkg::in_item_t item,
	input  logic              take,
	output logic              avail,
	output otp_pkg::work_t    work
);

	localparam int PTR_W = $clog2(Depth);
	localparam int CNT_W = $clog2(Depth + 1);

	otp_pkg::work_t   slot_q [Depth];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	otp_pkg::work_t   classified;
	logic [7:0]       request;
	logic [7:0]       level;
	logic             wr_en;
	logic             rd_en;

	// Classify the beat and form the 16-bit frame for a start request.
	always_comb begin
		level = (item.brightness > otp_pkg::BRIGHT_MAX) ? otp_pkg::BRIGHT_MAX
		                                                : item.brightness;
		request = otp_pkg::REQ_TOUCH;
		classified.kind = otp_pkg::KIND_IGNORE;
		unique case (item.operation)
			otp_pkg::OP_TICK: begin
				classified.kind = otp_pkg::KIND_TICK;
			end
			otp_pkg::OP_TOUCH: begin
				classified.kind = otp_pkg::KIND_TOUCH;
			end
			otp_pkg::OP_LIGHT: begin
				classified.kind = otp_pkg::KIND_LIGHT;
				request = otp_pkg::REQ_LIGHT | level;
			end
			default: begin
				classified.kind = otp_pkg::KIND_IGNORE;
			end
		endcase
		classified.sample = item.line_sample;
		classified.frame  = {request, otp_pkg::crc8_byte(request)};
	end

	assign full  = (count_q == CNT_W'(Depth));
	assign avail = (count_q != '0);
	assign wr_en = push && !full;
	assign rd_en = take && avail;
	assign work  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/otp_outq.sv -----
// Result queue of the touch panel master: holds finished result beats until
// the consumer pops them. Depends on otp_pkg.

module otp_outq #(
	parameter int Depth = otp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  otp_pkg::out_item_t wr_data,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output otp_pkg::out_item_t rd_data
);

	localparam int PTR_W = $clog2(Depth);
	localparam int CNT_W = $clog2(Depth + 1);

	otp_pkg::out_item_t slot_q [Depth];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (count_q == CNT_W'(Depth));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = pop && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/otp_engine.sv -----
// Session engine of the touch panel master, built on otp_pkg: steps the wire
// protocol one work beat per cycle while results have room; forms result beats.

module otp_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  otp_pkg::cfg_t      cfg,
	input  logic               avail,
	input  otp_pkg::work_t     work,
	output logic               take,
	input  logic               res_full,
	output logic               res_valid,
	output otp_pkg::out_item_t res
);

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_PREAMBLE = 3'd1;
	localparam logic [2:0] PH_STARTLOW = 3'd2;
	localparam logic [2:0] PH_SEND     = 3'd3;
	localparam logic [2:0] PH_HOLD     = 3'd4;
	localparam logic [2:0] PH_RELEASE  = 3'd5;
	localparam logic [2:0] PH_RECEIVE  = 3'd6;

	logic [2:0]  phase_q,   phase_d;
	logic [7:0]  unit_q,    unit_d;
	logic [5:0]  bit_q,     bit_d;
	logic [15:0] send_q,    send_d;
	logic [31:0] recv_q,    recv_d;
	logic [7:0]  crc_q,     crc_d;
	logic [2:0]  attempt_q, attempt_d;
	logic        touch_q,   touch_d;
	logic        pend_q,    pend_d;
	logic [11:0] last_x_q,  last_x_d;
	logic [11:0] last_y_q,  last_y_d;

	logic        fire;
	logic        finish;
	logic        pass;
	logic [7:0]  unit_next;
	logic [5:0]  bit_next;
	logic [2:0]  limit;
	logic [11:0] dec_x;
	logic [11:0] dec_y;

	assign fire      = avail && !res_full;
	assign take      = fire;
	assign res_valid = fire;
	assign unit_next = unit_q + 8'd1;
	assign bit_next  = bit_q + 6'd1;
	assign limit     = (cfg.retry_limit == 3'd0) ? 3'd1 : cfg.retry_limit;

	always_comb begin
		phase_d   = phase_q;
		unit_d    = unit_q;
		bit_d     = bit_q;
		send_d    = send_q;
		recv_d    = recv_q;
		crc_d     = crc_q;
		attempt_d = attempt_q;
		touch_d   = touch_q;
		pend_d    = pend_q;
		last_x_d  = last_x_q;
		last_y_d  = last_y_q;
		finish    = 1'b0;
		res       = '0;

		unique case (work.kind) inside
			otp_pkg::KIND_TOUCH, otp_pkg::KIND_LIGHT: begin
				if (phase_q == PH_IDLE) begin
					touch_d   = (work.kind == otp_pkg::KIND_TOUCH);
					send_d    = work.frame;
					attempt_d = 3'd0;
					phase_d   = PH_PREAMBLE;
					unit_d    = 8'd0;
					bit_d     = 6'd0;
					recv_d    = 32'd0;
					crc_d     = otp_pkg::CRC_INIT;
				end
			end
			otp_pkg::KIND_TICK: begin
				unique case (phase_q)
					PH_PREAMBLE: begin
						unit_d = unit_next;
						if (unit_next >= cfg.preamble_units) begin
							phase_d = PH_STARTLOW;
							unit_d  = 8'd0;
						end
					end
					PH_STARTLOW: begin
						unit_d = unit_next;
						if (unit_next >= {4'd0, cfg.start_low_units}) begin
							phase_d = PH_SEND;
							unit_d  = 8'd0;
							bit_d   = 6'd0;
						end
					end
					PH_SEND: begin
						bit_d = bit_next;
						if (bit_next >= otp_pkg::TX_BITS) phase_d = PH_HOLD;
					end
					PH_HOLD: begin
						phase_d = PH_RELEASE;
					end
					PH_RELEASE: begin
						recv_d  = {31'd0, work.sample};
						crc_d   = otp_pkg::crc8_step(crc_q, work.sample);
						bit_d   = 6'd1;
						phase_d = PH_RECEIVE;
					end
					PH_RECEIVE: begin
						recv_d = {recv_q[30:0], work.sample};
						bit_d  = bit_next;
						// The check byte covers only the first three received bytes.
						if (bit_next <= otp_pkg::RX_CRC_BITS) begin
							crc_d = otp_pkg::crc8_step(crc_q, work.sample);
						end
						if (bit_next >= otp_pkg::RX_BITS) finish = 1'b1;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		pass  = (crc_q == recv_d[7:0]);
		dec_x = {recv_d[31:28], recv_d[23:16]};
		dec_y = {recv_d[27:24], recv_d[15:8]};

		if (finish) begin
			attempt_d = attempt_q + 3'd1;
			if (pass) begin
				res.done_res = 1'b1;
				res.success  = 1'b1;
				phase_d      = PH_IDLE;
				if (touch_q) begin
					res.pos_x    = dec_x;
					res.pos_y    = dec_y;
					res.pen_down = (dec_x != otp_pkg::POS_NONE) && (dec_y != otp_pkg::POS_NONE);
					if (res.pen_down) begin
						res.pen_event = otp_pkg::EV_PRESS;
						last_x_d      = dec_x;
						last_y_d      = dec_y;
						pend_d        = 1'b1;
					end else if (pend_q) begin
						res.pen_event = otp_pkg::EV_RELEASE;
						res.pos_x     = last_x_q;
						res.pos_y     = last_y_q;
						pend_d        = 1'b0;
					end
				end
			end else if (attempt_d >= limit) begin
				res.done_res = 1'b1;
				phase_d      = PH_IDLE;
			end else begin
				phase_d = PH_PREAMBLE;
				unit_d  = 8'd0;
				bit_d   = 6'd0;
				recv_d  = 32'd0;
				crc_d   = otp_pkg::CRC_INIT;
			end
		end

		res.drive_enable = 1'b1;
		res.drive_level  = 1'b1;
		unique case (phase_d) inside
			PH_STARTLOW: res.drive_level = 1'b0;
			PH_SEND:     res.drive_level = send_d[~bit_d[3:0]];
			PH_HOLD:     res.drive_level = send_d[0];
			PH_RELEASE, PH_RECEIVE: begin
				res.drive_enable = 1'b0;
				res.drive_level  = 1'b0;
			end
			default: begin
			end
		endcase
		res.busy_res = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			unit_q    <= '0;
			bit_q     <= '0;
			send_q    <= '0;
			recv_q    <= '0;
			crc_q     <= '0;
			attempt_q <= '0;
			touch_q   <= 1'b0;
			pend_q    <= 1'b0;
			last_x_q  <= '0;
			last_y_q  <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			unit_q    <= unit_d;
			bit_q     <= bit_d;
			send_q    <= send_d;
			recv_q    <= recv_d;
			crc_q     <= crc_d;
			attempt_q <= attempt_d;
			touch_q   <= touch_d;
			pend_q    <= pend_d;
			last_x_q  <= last_x_d;
			last_y_q  <= last_y_d;
		end
	end

`ifndef SYNTHESIS
	a_start_enters_preamble: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (phase_q == PH_IDLE) &&
		((work.kind == otp_pkg::KIND_TOUCH) || (work.kind == otp_pkg::KIND_LIGHT))
		|=> (phase_q == PH_PREAMBLE))
		else $error("start from idle did not open a preamble");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.done_res |-> !res.busy_res)
		else $error("finished command still reports busy");

	a_event_needs_pass: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (res.pen_event != otp_pkg::EV_NONE) |-> res.success && touch_q)
		else $error("pen event without a passed touch query");

	a_receive_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RECEIVE) |-> (bit_q >= 6'd1) && (bit_q < otp_pkg::RX_BITS))
		else $error("receive bit count out of range");
`endif

endmodule

// ----- hw/rtl/onewire_touch_panel_master.sv -----
// Top level of the one-wire touch panel master: configuration registers,
// input front, session engine and result queue. Depends on otp_pkg,
// otp_front, otp_engine and otp_outq.

// Each input beat is one bit-time tick or one start command, and the block
// returns exactly one result beat per input beat, describing the wire drive
// and status after that beat. Throughput is one beat per clock cycle while
// the result queue has room: the session engine updates its counters, shift
// registers and running CRC for each beat it takes, so the input queue drains
// at one beat a cycle. A beat is registered in the input queue, and its
// result, formed by the engine, is registered in the result queue that
// drives the result ports. Start commands while a session sequence is busy
// are dropped and produce a plain status beat, as does the unused operation
// code. The received check byte is computed on the fly as the response bits
// arrive, so the pass or fail decision is ready at the 32nd sample.
// Configuration registers (retry limit, preamble length, start pulse length)
// are written through the cfg port, which is always ready; write them only
// while no beat is in flight. A write to an index past the register list is
// taken and has no effect.

module onewire_touch_panel_master #(
	parameter int QueueDepth = otp_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  otp_pkg::in_item_t              item,
	output logic                           empty,
	input  logic                           pop,
	output otp_pkg::out_item_t             result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [otp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [otp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	otp_pkg::cfg_t      cfg_q;
	otp_pkg::work_t     work;
	otp_pkg::out_item_t eng_res;
	logic               work_avail;
	logic               work_take;
	logic               res_valid;
	logic               res_full;

	// The configuration port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_limit     <= otp_pkg::RETRY_LIMIT_RESET;
			cfg_q.preamble_units  <= otp_pkg::PREAMBLE_UNITS_RESET;
			cfg_q.start_low_units <= otp_pkg::START_LOW_UNITS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				otp_pkg::CFG_RETRY_LIMIT:     cfg_q.retry_limit     <= cfg_data[2:0];
				otp_pkg::CFG_PREAMBLE_UNITS:  cfg_q.preamble_units  <= cfg_data[7:0];
				otp_pkg::CFG_START_LOW_UNITS: cfg_q.start_low_units <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Front: takes input beats, classifies them and builds request frames.
	otp_front #(
		.Depth(QueueDepth)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.take  (work_take),
		.avail (work_avail),
		.work  (work)
	);

	// Back: steps the session one beat per cycle whenever a result slot is free.
	otp_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.avail    (work_avail),
		.work     (work),
		.take     (work_take),
		.res_full (res_full),
		.res_valid(res_valid),
		.res      (eng_res)
	);

	// Result queue: decouples the engine from a stalling consumer.
	otp_outq #(
		.Depth(QueueDepth)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_valid),
		.wr_data(eng_res),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.rd_data(result)
	);

endmodule
